// ===== hw/rtl/segment_pair_distance_defines.svh =====
// Assertion macros for the segment pair distance block.
`ifndef SEGMENT_PAIR_DISTANCE_DEFINES_SVH
`define SEGMENT_PAIR_DISTANCE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define SPD_ASSERT_NOW(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("label failed");

// Next-cycle implication, sampled on clk, off during rst.
`define SPD_ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("label failed");

`endif

// ===== hw/rtl/spd_pkg.sv =====
// Shared types and constants for the segment pair distance block.
package spd_pkg;

  localparam int CW       = 24;            // coordinate width
  localparam int DW       = CW + 1;        // coordinate difference
  localparam int PRW      = 2 * DW;        // signed product
  localparam int SW       = PRW + 1;       // signed sum of two products
  localparam int MW       = SW - 1;        // magnitude of such a sum
  localparam int HW       = (MW + 1) / 2;  // half of a magnitude, for squaring
  localparam int QB       = CW + 2;        // root result bits
  localparam int PW       = 4 * CW + 7;    // root compare width
  localparam int DIST_W   = 25;
  localparam int UNIT_NS  = 6 + QB;        // stages inside one segment unit
  localparam int NS       = UNIT_NS + 2;   // total stages, last is output
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  typedef struct packed {
    logic signed [CW-1:0] p1_x;
    logic signed [CW-1:0] p1_y;
    logic signed [CW-1:0] p2_x;
    logic signed [CW-1:0] p2_y;
    logic signed [CW-1:0] q1_x;
    logic signed [CW-1:0] q1_y;
    logic signed [CW-1:0] q2_x;
    logic signed [CW-1:0] q2_y;
  } query_t;

  typedef struct packed {
    logic              crossing;
    logic [DIST_W-1:0] distance;
  } result_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
  } point_t;

  typedef struct packed {
    logic neg;
    logic zero;
  } sign_t;

endpackage

// ===== hw/rtl/segment_pair_distance.sv =====
// Top level: distance between two 2D segments, fully pipelined.
//
//  channel | signals                          | word
//  --------+----------------------------------+-----------------------------
//  query   | query_valid, query_ready, query  | endpoints P1 P2 Q1 Q2
//  result  | result_valid, result_ready, result | crossing flag, distance
//
// One word enters per cycle unless a result stall has backed the pipe up;
// 34 register stages lie between an accepted query and its result.
// The depth comes from the 26-stage bit-per-stage square root behind the
// product, sum and squaring stages, four such units side by side.
// Reset (rst, synchronous) clears only the stage valid bits.
// Each stage holds while its successor is full and stalled, so bubbles close
// up and a stall at the result drops or repeats nothing.
`include "segment_pair_distance_defines.svh"

module segment_pair_distance (
  input  logic             clk,
  input  logic             rst,
  input  logic             query_valid,
  output logic             query_ready,
  input  spd_pkg::query_t  query,
  output logic             result_valid,
  input  logic             result_ready,
  output spd_pkg::result_t result
);

  localparam int CW      = spd_pkg::CW;
  localparam int QB      = spd_pkg::QB;
  localparam int NS      = spd_pkg::NS;
  localparam int UNIT_NS = spd_pkg::UNIT_NS;
  localparam int DIST_W  = spd_pkg::DIST_W;

  // stage valid bits and per-stage advance
  logic [NS-1:0] vld, en;

  assign en[NS-1] = !vld[NS-1] || result_ready;
  for (genvar s = 0; s < NS - 1; s++) begin : g_en
    assign en[s] = !vld[s] || en[s+1];
  end

  assign query_ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= query_valid;
      for (int s = 1; s < NS; s++) begin
        if (en[s]) vld[s] <= vld[s-1];
      end
    end
  end

  // endpoints as points
  spd_pkg::point_t pa, pb, pc, pd;
  assign pa = '{x: query.p1_x, y: query.p1_y};
  assign pb = '{x: query.p2_x, y: query.p2_y};
  assign pc = '{x: query.q1_x, y: query.q1_y};
  assign pd = '{x: query.q2_x, y: query.q2_y};

  // four point-to-segment units; their cross signs are the orientations
  spd_pkg::sign_t  sg_a, sg_b, sg_c, sg_d;
  logic [QB-1:0]   dst_a, dst_b, dst_c, dst_d;

  spd_seg_unit u_seg_a (.clk, .p(pa), .a(pc), .b(pd), .en(en[UNIT_NS-1:0]),
                        .cr_sign(sg_a), .gap(dst_a));
  spd_seg_unit u_seg_b (.clk, .p(pb), .a(pc), .b(pd), .en(en[UNIT_NS-1:0]),
                        .cr_sign(sg_b), .gap(dst_b));
  spd_seg_unit u_seg_c (.clk, .p(pc), .a(pa), .b(pb), .en(en[UNIT_NS-1:0]),
                        .cr_sign(sg_c), .gap(dst_c));
  spd_seg_unit u_seg_d (.clk, .p(pd), .a(pa), .b(pb), .en(en[UNIT_NS-1:0]),
                        .cr_sign(sg_d), .gap(dst_d));

  // bounding interval overlap on raw inputs
  logic signed [CW-1:0] x1l, x1h, x2l, x2h, y1l, y1h, y2l, y2h;
  logic signed [CW-1:0] xlo, xhi, ylo, yhi;
  logic                 span_ok;
  always_comb begin
    x1l = (query.p1_x < query.p2_x) ? query.p1_x : query.p2_x;
    x1h = (query.p1_x < query.p2_x) ? query.p2_x : query.p1_x;
    x2l = (query.q1_x < query.q2_x) ? query.q1_x : query.q2_x;
    x2h = (query.q1_x < query.q2_x) ? query.q2_x : query.q1_x;
    y1l = (query.p1_y < query.p2_y) ? query.p1_y : query.p2_y;
    y1h = (query.p1_y < query.p2_y) ? query.p2_y : query.p1_y;
    y2l = (query.q1_y < query.q2_y) ? query.q1_y : query.q2_y;
    y2h = (query.q1_y < query.q2_y) ? query.q2_y : query.q1_y;
    xlo = (x1l > x2l) ? x1l : x2l;
    xhi = (x1h < x2h) ? x1h : x2h;
    ylo = (y1l > y2l) ? y1l : y2l;
    yhi = (y1h < y2h) ? y1h : y2h;
    span_ok = (xlo <= xhi) && (ylo <= yhi);
  end

  // orientation pairs must not share a strict sign
  logic straddle_ab, straddle_cd;
  assign straddle_ab = !((!sg_c.neg && !sg_c.zero && !sg_d.neg && !sg_d.zero) ||
                         (sg_c.neg && sg_d.neg));
  assign straddle_cd = !((!sg_a.neg && !sg_a.zero && !sg_b.neg && !sg_b.zero) ||
                         (sg_a.neg && sg_b.neg));

  // flag line: span test, then full hit from stage 3 on
  logic flag [0:NS-2];
  always_ff @(posedge clk) begin
    if (en[0]) flag[0] <= span_ok;
    if (en[1]) flag[1] <= flag[0];
    if (en[2]) flag[2] <= flag[1];
    if (en[3]) flag[3] <= flag[2] && straddle_ab && straddle_cd;
    for (int s = 4; s < NS - 1; s++) begin
      if (en[s]) flag[s] <= flag[s-1];
    end
  end

  // minimum of the four, then saturate into the result word
  logic [QB-1:0] m01, m23, best;
  always_ff @(posedge clk) begin
    if (en[NS-2]) begin
      m01 <= (dst_b < dst_a) ? dst_b : dst_a;
      m23 <= (dst_d < dst_c) ? dst_d : dst_c;
    end
  end

  assign best = (m23 < m01) ? m23 : m01;

  always_ff @(posedge clk) begin
    if (en[NS-1]) begin
      result.crossing <= flag[NS-2];
      if (flag[NS-2]) begin
        result.distance <= '0;
      end else if (best > QB'(spd_pkg::DIST_MAX)) begin
        result.distance <= spd_pkg::DIST_MAX;
      end else begin
        result.distance <= DIST_W'(best);
      end
    end
  end

  assign result_valid = vld[NS-1];

  // touching segments report zero
  `SPD_ASSERT_NOW(a_cross_zero, result_valid && result.crossing, result.distance == '0)
  // the query side only backs up when the whole pipe is full and stalled
  `SPD_ASSERT_NOW(a_backpressure, !query_ready, result_valid && !result_ready && (&vld))
  // an accepted word occupies the first stage
  `SPD_ASSERT_NEXT(a_enter, query_valid && query_ready, vld[0])

endmodule

// ===== hw/rtl/spd_seg_unit.sv =====
// Pipelined point-to-segment distance, truncated, with cross sign tap.
module spd_seg_unit (
  input  logic                          clk,
  input  spd_pkg::point_t               p,
  input  spd_pkg::point_t               a,
  input  spd_pkg::point_t               b,
  input  logic [spd_pkg::UNIT_NS-1:0]   en,
  output spd_pkg::sign_t                cr_sign,
  output logic [spd_pkg::QB-1:0]        gap
);

  localparam int CW  = spd_pkg::CW;
  localparam int DW  = spd_pkg::DW;
  localparam int PRW = spd_pkg::PRW;
  localparam int SW  = spd_pkg::SW;
  localparam int MW  = spd_pkg::MW;
  localparam int HW  = spd_pkg::HW;
  localparam int QB  = spd_pkg::QB;
  localparam int PW  = spd_pkg::PW;

  // stage 0: differences
  logic signed [DW-1:0] bax, bay, pax, pay, pbx, pby;
  always_ff @(posedge clk) begin
    if (en[0]) begin
      bax <= $signed({b.x[CW-1], b.x}) - $signed({a.x[CW-1], a.x});
      bay <= $signed({b.y[CW-1], b.y}) - $signed({a.y[CW-1], a.y});
      pax <= $signed({p.x[CW-1], p.x}) - $signed({a.x[CW-1], a.x});
      pay <= $signed({p.y[CW-1], p.y}) - $signed({a.y[CW-1], a.y});
      pbx <= $signed({p.x[CW-1], p.x}) - $signed({b.x[CW-1], b.x});
      pby <= $signed({p.y[CW-1], p.y}) - $signed({b.y[CW-1], b.y});
    end
  end

  // stage 1: products
  logic signed [PRW-1:0] m_lx, m_ly, m_d1x, m_d1y, m_d2x, m_d2y;
  logic signed [PRW-1:0] m_c1, m_c2, m_sax, m_say, m_sbx, m_sby;
  always_ff @(posedge clk) begin
    if (en[1]) begin
      m_lx  <= bax * bax;
      m_ly  <= bay * bay;
      m_d1x <= pax * bax;
      m_d1y <= pay * bay;
      m_d2x <= pbx * bax;
      m_d2y <= pby * bay;
      m_c1  <= bax * pay;
      m_c2  <= bay * pax;
      m_sax <= pax * pax;
      m_say <= pay * pay;
      m_sbx <= pbx * pbx;
      m_sby <= pby * pby;
    end
  end

  // stage 2: sums
  logic signed [SW-1:0] len2, d1, d2n, cr, sa, sb;
  always_ff @(posedge clk) begin
    if (en[2]) begin
      len2 <= SW'(m_lx) + SW'(m_ly);
      d1   <= SW'(m_d1x) + SW'(m_d1y);
      d2n  <= SW'(m_d2x) + SW'(m_d2y);
      cr   <= SW'(m_c1) - SW'(m_c2);
      sa   <= SW'(m_sax) + SW'(m_say);
      sb   <= SW'(m_sbx) + SW'(m_sby);
    end
  end

  assign cr_sign.neg  = cr[SW-1];
  assign cr_sign.zero = (cr == '0);

  // stage 3: choose perpendicular or endpoint path
  logic          perp3;
  logic [MW-1:0] len3, crmag3, smin3;
  logic signed [SW-1:0] cr_abs;
  assign cr_abs = cr[SW-1] ? -cr : cr;
  always_ff @(posedge clk) begin
    if (en[3]) begin
      perp3  <= (len2 != '0) && !d1[SW-1] && (d2n[SW-1] || (d2n == '0));
      len3   <= len2[MW-1:0];
      crmag3 <= cr_abs[MW-1:0];
      smin3  <= (sa < sb) ? sa[MW-1:0] : sb[MW-1:0];
    end
  end

  // stage 4: square the cross magnitude in halves
  logic [HW-1:0]   cr_hi, cr_lo;
  logic [2*HW-1:0] hh4, hl4, ll4;
  logic            perp4;
  logic [MW-1:0]   len4, smin4;
  assign cr_hi = HW'(crmag3 >> HW);
  assign cr_lo = crmag3[HW-1:0];
  always_ff @(posedge clk) begin
    if (en[4]) begin
      hh4   <= cr_hi * cr_hi;
      hl4   <= cr_hi * cr_lo;
      ll4   <= cr_lo * cr_lo;
      perp4 <= perp3;
      len4  <= len3;
      smin4 <= smin3;
    end
  end

  // stage 5: root operands
  logic [PW-1:0] n5, l5;
  always_ff @(posedge clk) begin
    if (en[5]) begin
      if (perp4) begin
        n5 <= (PW'(hh4) << (2 * HW)) + (PW'(hl4) << (HW + 1)) + PW'(ll4);
        l5 <= PW'(len4);
      end else begin
        n5 <= PW'(smin4);
        l5 <= PW'(1);
      end
    end
  end

  // root stages: largest q with q*q*l <= n, one bit a stage.
  // rp tracks q*q*l and rqv tracks q*l so each trial is only adds.
  logic [QB-1:0] rq  [0:QB];
  logic [PW-1:0] rp  [0:QB];
  logic [PW-1:0] rqv [0:QB];
  logic [PW-1:0] rn  [0:QB];
  logic [PW-1:0] rl  [0:QB];

  assign rq[0]  = '0;
  assign rp[0]  = '0;
  assign rqv[0] = '0;
  assign rn[0]  = n5;
  assign rl[0]  = l5;

  for (genvar k = 0; k < QB; k++) begin : g_root
    localparam int BIT = QB - 1 - k;
    logic [PW-1:0] trial;
    assign trial = rp[k] + (rqv[k] << (BIT + 1)) + (rl[k] << (2 * BIT));
    always_ff @(posedge clk) begin
      if (en[6+k]) begin
        rn[k+1] <= rn[k];
        rl[k+1] <= rl[k];
        if (trial <= rn[k]) begin
          rq[k+1]  <= rq[k] | (QB'(1) << BIT);
          rp[k+1]  <= trial;
          rqv[k+1] <= rqv[k] + (rl[k] << BIT);
        end else begin
          rq[k+1]  <= rq[k];
          rp[k+1]  <= rp[k];
          rqv[k+1] <= rqv[k];
        end
      end
    end
  end

  assign gap = rq[QB];

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the segment pair distance block.
`timescale 1ns / 1ps

module tb_top;

  typedef spd_pkg::query_t  query_t;
  typedef spd_pkg::result_t result_t;

  localparam int CW     = spd_pkg::CW;
  localparam int QB     = spd_pkg::QB;
  localparam int DIST_W = spd_pkg::DIST_W;
  localparam logic [DIST_W-1:0] DIST_MAX = spd_pkg::DIST_MAX;

  localparam int RANDOM_WORDS = 500;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 60;   // more than the 34-stage pipeline depth
  localparam int HOLD_CYCLES  = 300;  // long result stall, fills the pipeline
  localparam int HOLD_AT_WORD = 150;

  localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

  // Keeps the expected results in order. Each one is worked out with exact
  // integer geometry when its query word is accepted.
  class DistanceBoard;
    result_t pending[$];
    int      mismatches;

    static function automatic int sign_of(longint v);
      return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
    endfunction

    // (a - o) x (b - o)
    static function automatic longint turn(longint ox, longint oy, longint ax, longint ay,
                                           longint bx, longint by);
      return (ax - ox) * (by - oy) - (ay - oy) * (bx - ox);
    endfunction

    // largest r with r*r*den <= num
    static function automatic logic [QB-1:0] root_ratio(logic [127:0] num,
                                                       logic [127:0] den);
      logic [QB-1:0] r;
      logic [QB-1:0] c;
      logic [127:0]  cw;
      r = '0;
      for (int b = QB - 1; b >= 0; b--) begin
        c  = r | (QB'(1) << b);
        cw = 128'(c);
        if (cw * cw * den <= num) r = c;
      end
      return r;
    endfunction

    static function automatic logic [QB-1:0] point_gap(longint px, longint py,
                                                      longint ax, longint ay);
      return root_ratio(128'((px - ax) * (px - ax) + (py - ay) * (py - ay)), 128'd1);
    endfunction

    // distance from P to segment AB, truncated
    static function automatic logic [QB-1:0] seg_gap(longint px, longint py, longint ax,
                                                    longint ay, longint bx, longint by);
      longint        len2;
      longint        dot_a;
      longint        dot_b;
      longint        cr;
      logic [127:0]  crm;
      logic [QB-1:0] ea;
      logic [QB-1:0] eb;
      len2  = (bx - ax) * (bx - ax) + (by - ay) * (by - ay);
      dot_a = (px - ax) * (bx - ax) + (py - ay) * (by - ay);
      dot_b = (px - bx) * (ax - bx) + (py - by) * (ay - by);
      if (len2 != 0 && dot_a >= 0 && dot_b >= 0) begin
        cr  = turn(ax, ay, bx, by, px, py);
        crm = 128'((cr < 0) ? -cr : cr);
        return root_ratio(crm * crm, 128'(len2));
      end
      ea = point_gap(px, py, ax, ay);
      eb = point_gap(px, py, bx, by);
      return (ea < eb) ? ea : eb;
    endfunction

    static function automatic bit spans_meet(longint a, longint b, longint c, longint d);
      longint lo1, hi1, lo2, hi2;
      lo1 = (a < b) ? a : b;  hi1 = (a < b) ? b : a;
      lo2 = (c < d) ? c : d;  hi2 = (c < d) ? d : c;
      return ((lo1 > lo2) ? lo1 : lo2) <= ((hi1 < hi2) ? hi1 : hi2);
    endfunction

    static function automatic result_t predict(query_t q);
      longint        ax, ay, bx, by, cx, cy, dx, dy;
      logic [QB-1:0] best;
      logic [QB-1:0] v;
      result_t       r;
      ax = longint'(q.p1_x); ay = longint'(q.p1_y);
      bx = longint'(q.p2_x); by = longint'(q.p2_y);
      cx = longint'(q.q1_x); cy = longint'(q.q1_y);
      dx = longint'(q.q2_x); dy = longint'(q.q2_y);
      r.crossing = spans_meet(ax, bx, cx, dx) && spans_meet(ay, by, cy, dy)
        && sign_of(turn(ax, ay, bx, by, cx, cy)) * sign_of(turn(ax, ay, bx, by, dx, dy)) <= 0
        && sign_of(turn(cx, cy, dx, dy, ax, ay)) * sign_of(turn(cx, cy, dx, dy, bx, by)) <= 0;
      r.distance = '0;
      if (!r.crossing) begin
        best = seg_gap(ax, ay, cx, cy, dx, dy);
        v = seg_gap(bx, by, cx, cy, dx, dy); if (v < best) best = v;
        v = seg_gap(cx, cy, ax, ay, bx, by); if (v < best) best = v;
        v = seg_gap(dx, dy, ax, ay, bx, by); if (v < best) best = v;
        r.distance = (best > QB'(DIST_MAX)) ? DIST_MAX : best[DIST_W-1:0];
      end
      return r;
    endfunction

    function void note_query(query_t q);
      pending.push_back(predict(q));
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: crossing=%0d distance=%0d",
                   got.crossing, got.distance);
        return;
      end
      want = pending.pop_front();
      if (want.crossing !== got.crossing || want.distance !== got.distance) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: crossing exp %0d got %0d, distance exp %0d got %0d",
                   want.crossing, got.crossing, want.distance, got.distance);
      end
    endfunction
  endclass

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    query_valid = 1'b0;
  logic    query_ready;
  query_t  query = '0;
  logic    result_valid;
  logic    result_ready = 1'b0;
  result_t result;

  DistanceBoard board = new();
  int sent_words = 0;
  int idle_phase = 0;   // 0: sender 33 / receiver 69, 1: swapped, 2: no idling
  int hold_left  = 0;
  bit hold_done  = 1'b0;
  int cycles     = 0;

  segment_pair_distance dut (
    .clk(clk), .rst(rst),
    .query_valid(query_valid), .query_ready(query_ready), .query(query),
    .result_valid(result_valid), .result_ready(result_ready), .result(result)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Cycle limit, catches a hung pipeline.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Result side: check each accepted word, then pick next ready. One long
  // stall is thrown in while the sender keeps going, so the input backs up.
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) board.check_result(result);
    if (!hold_done && sent_words >= HOLD_AT_WORD) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      result_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      result_ready <= 1'b0;
    end else if (idle_phase == 0) begin
      result_ready <= ($urandom_range(0, 99) >= 69);
    end else if (idle_phase == 1) begin
      result_ready <= ($urandom_range(0, 99) >= 33);
    end else begin
      result_ready <= 1'b1;
    end
  end

  // Offers one word and holds it until taken; may idle first. Valid stays
  // up after the accept unless the next word idles.
  task automatic send_query(query_t q);
    int gap_pct;
    gap_pct = (idle_phase == 0) ? 33 : ((idle_phase == 1) ? 69 : 0);
    while ($urandom_range(0, 99) < gap_pct) begin
      query_valid <= 1'b0;
      @(posedge clk);
    end
    query_valid <= 1'b1;
    query <= q;
    @(posedge clk);
    while (!query_ready) @(posedge clk);
    board.note_query(q);
    sent_words++;
  endtask

  function automatic query_t make_query(int x1, int y1, int x2, int y2,
                                        int x3, int y3, int x4, int y4);
    query_t q;
    q.p1_x = x1[CW-1:0]; q.p1_y = y1[CW-1:0];
    q.p2_x = x2[CW-1:0]; q.p2_y = y2[CW-1:0];
    q.q1_x = x3[CW-1:0]; q.q1_y = y3[CW-1:0];
    q.q2_x = x4[CW-1:0]; q.q2_y = y4[CW-1:0];
    return q;
  endfunction

  function automatic int spread(int r);
    return $signed($urandom_range(0, 2 * r)) - r;
  endfunction

  function automatic int corner_value();
    case ($urandom_range(0, 3))
      0: return int'(CMAX);
      1: return int'(CMIN);
      2: return 0;
      default: return -1;
    endcase
  endfunction

  // Random query; most are local clusters so crossings and near misses occur.
  function automatic query_t random_query();
    int     cx, cy, rad, dx, dy, k;
    query_t q;
    cx  = spread(1 << 22);
    cy  = spread(1 << 22);
    rad = ($urandom_range(0, 2) == 0) ? 16 : (($urandom_range(0, 1) == 0) ? 1024 : 65535);
    case ($urandom_range(0, 9))
      4, 9: begin
        q = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
      end
      5: begin
        q = make_query(cx + spread(rad), cy + spread(rad), cx, cy,
                       cx, cy, cx + spread(rad), cy + spread(rad));
      end
      6: begin
        dx = spread(100); dy = spread(100);
        k  = spread(1000);
        q = make_query(cx, cy, cx + dx * spread(1000), cy + dy * k,
                       cx + dx * spread(1000), cy + dy * spread(1000),
                       cx + dx * spread(1000), cy + dy * spread(1000));
        q.p2_x = CW'(cx + dx * k);
        q.q1_y = CW'(q.q1_x - cx + cy);   // keep the colinear x/y tie on some axis
        if (dx != 0) begin
          k = spread(1000); q.q1_x = CW'(cx + dx * k); q.q1_y = CW'(cy + dy * k);
          k = spread(1000); q.q2_x = CW'(cx + dx * k); q.q2_y = CW'(cy + dy * k);
        end
      end
      7: begin
        q = make_query(cx + spread(rad), cy + spread(rad), 0, 0,
                       cx + spread(rad), cy + spread(rad), cx + spread(rad), cy + spread(rad));
        q.p2_x = q.p1_x; q.p2_y = q.p1_y;
        if ($urandom_range(0, 1) == 0) begin
          q.q2_x = q.q1_x; q.q2_y = q.q1_y;
        end
      end
      8: begin
        q = make_query(corner_value(), corner_value(), corner_value(), corner_value(),
                       corner_value(), corner_value(), corner_value(), corner_value());
      end
      default: begin
        q = make_query(cx + spread(rad), cy + spread(rad), cx + spread(rad), cy + spread(rad),
                       cx + spread(rad), cy + spread(rad), cx + spread(rad), cy + spread(rad));
      end
    endcase
    return q;
  endfunction

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed words: corners, touching and crossing shapes, colinear cases,
    // degenerate segments, foot of the perpendicular inside and outside.
    send_query(make_query(int'(CMIN), int'(CMIN), int'(CMIN), int'(CMIN),
                          int'(CMAX), int'(CMAX), int'(CMAX), int'(CMAX)));
    send_query(make_query(int'(CMAX), int'(CMIN), int'(CMAX), int'(CMIN),
                          int'(CMIN), int'(CMAX), int'(CMIN), int'(CMAX)));
    send_query(make_query(int'(CMIN), int'(CMIN), int'(CMAX), int'(CMAX),
                          int'(CMIN), int'(CMAX), int'(CMAX), int'(CMIN)));
    send_query(make_query(int'(CMAX), int'(CMAX), int'(CMAX), int'(CMAX),
                          int'(CMAX), int'(CMAX), int'(CMAX), int'(CMAX)));
    send_query(make_query(0, 0, 0, 0, 0, 0, 0, 0));
    send_query(make_query(-1, -1, -1, -1, 0, 0, 0, 0));
    send_query(make_query(0, 0, 512, 512, 0, 512, 512, 0));       // X crossing
    send_query(make_query(0, 0, 512, 0, 256, 0, 256, 300));       // T touch
    send_query(make_query(0, 0, 512, 0, 512, 0, 900, 40));        // shared endpoint
    send_query(make_query(0, 0, 512, 0, 300, 0, 900, 0));         // colinear overlap
    send_query(make_query(0, 0, 512, 0, 512, 0, 900, 0));         // colinear touch
    send_query(make_query(0, 0, 512, 0, 600, 0, 900, 0));         // colinear apart
    send_query(make_query(0, 0, 0, 256, 0, 300, 0, 900));         // colinear apart in y
    send_query(make_query(0, 0, 512, 0, 100, 300, 400, 300));     // parallel
    send_query(make_query(0, 0, 1024, 0, 300, 77, 300, 900));     // foot inside
    send_query(make_query(0, 0, 1024, 0, 1500, 3, 2000, 700));    // nearest endpoint
    send_query(make_query(0, 0, 0, 0, 100, 100, 700, 100));       // point vs segment
    send_query(make_query(5, 5, 5, 5, 5, 5, 5, 5));               // same point twice
    send_query(make_query(5, 5, 5, 5, 9, 8, 9, 8));               // two points
    send_query(make_query(300, 100, 300, 100, 0, 0, 600, 200));   // point on segment
    send_query(make_query(1, 0, 3, 1, 0, 1, 2, 3));               // skew, small
    send_query(make_query(int'(CMIN), 0, int'(CMAX), 0, 0, 1, 0, int'(CMAX)));

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i == RANDOM_WORDS / 3) idle_phase = 1;
      if (i == 2 * RANDOM_WORDS / 3) idle_phase = 2;
      send_query(random_query());
    end
    query_valid <= 1'b0;

    while (board.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/spd_pkg.sv
hw/rtl/spd_seg_unit.sv
hw/rtl/segment_pair_distance.sv
sim/tb_top.sv
